FILE: rtl/lrgd_pkg.sv
// Shared types, widths and the control program for the gradient descent trainer.
// Used by the channel interfaces and every module of the block; depends on nothing.
`default_nettype none

package lrgd_pkg;

  localparam int WORD_W   = 32;
  localparam int SUM_W    = 64;
  localparam int LOSS_W   = 47;
  localparam int EPOCH_W  = 16;
  localparam int BATCH_W  = 9;
  localparam int LR_W     = 17;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 47;
  localparam int STEP_W   = 5;
  localparam int MEAN_W   = 47;
  localparam int MEAN_SPLIT = 24;

  localparam int DEFAULT_MAX_BATCH     = 256;
  localparam int DEFAULT_FRACTION_BITS = 16;

  localparam logic [LR_W-1:0]    LR_RESET         = LR_W'(6554);
  localparam logic [BATCH_W-1:0] BATCH_RESET      = BATCH_W'(4);
  localparam logic [EPOCH_W-1:0] MAX_EPOCHS_RESET = EPOCH_W'(500);

  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_COUNT       = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_EPOCHS        = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_LOSS_THRESHOLD    = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SLOPE     = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_INTERCEPT = CFG_IDX_W'(5);

  typedef enum logic [4:0] {
    OP_NOP,
    OP_WAIT_IN,
    OP_MUL_XS,
    OP_PRED,
    OP_ERR,
    OP_MUL_XE,
    OP_GRAD,
    OP_LOSS,
    OP_DIV_GRAD,
    OP_MEAN,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_STEP_SUM,
    OP_APPLY,
    OP_DIV_LOSS,
    OP_MEAN_LOSS,
    OP_JUDGE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_ALWAYS,
    BR_NO_GO,
    BR_NOT_FULL,
    BR_DIV_BUSY,
    BR_OUT_BUSY
  } br_t;

  localparam logic SEL_SLOPE     = 1'b0;
  localparam logic SEL_INTERCEPT = 1'b1;

  typedef struct packed {
    op_t               op;
    br_t               br;
    logic              sel;
    logic [STEP_W-1:0] target;
  } ctrl_word_t;

  typedef struct packed {
    logic go;
    logic full;
    logic div_busy;
    logic out_busy;
  } seq_flags_t;

  typedef struct packed {
    logic done;
    logic full;
    logic div_busy;
  } dp_status_t;

  typedef struct packed {
    logic [LR_W-1:0]    learning_rate;
    logic [BATCH_W-1:0] batch_count;
    logic [EPOCH_W-1:0] max_epochs;
    logic [LOSS_W-1:0]  loss_threshold;
  } cfg_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] slope;
    logic signed [WORD_W-1:0] intercept;
    logic [LOSS_W-1:0]        mean_loss;
    logic [EPOCH_W-1:0]       epoch_number;
    logic                     finished;
  } result_t;

  localparam logic [STEP_W-1:0] STEP_IDLE           = STEP_W'(0);
  localparam logic [STEP_W-1:0] STEP_WAIT_DIV_SLOPE = STEP_W'(8);
  localparam logic [STEP_W-1:0] STEP_WAIT_DIV_ICPT  = STEP_W'(15);
  localparam logic [STEP_W-1:0] STEP_WAIT_DIV_LOSS  = STEP_W'(22);
  localparam logic [STEP_W-1:0] STEP_WAIT_OUT       = STEP_W'(25);

  // Per-sample work takes steps 0 to 6, the batch close steps 7 to 26.
  function automatic ctrl_word_t lrgd_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    case (step)
      STEP_IDLE:           w = '{OP_WAIT_IN,   BR_NO_GO,    SEL_SLOPE,     STEP_IDLE};
      STEP_W'(1):          w = '{OP_MUL_XS,    BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(2):          w = '{OP_PRED,      BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(3):          w = '{OP_ERR,       BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(4):          w = '{OP_MUL_XE,    BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(5):          w = '{OP_GRAD,      BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(6):          w = '{OP_LOSS,      BR_NOT_FULL, SEL_SLOPE,     STEP_IDLE};
      STEP_W'(7):          w = '{OP_DIV_GRAD,  BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_WAIT_DIV_SLOPE: w = '{OP_NOP,       BR_DIV_BUSY, SEL_SLOPE,     STEP_WAIT_DIV_SLOPE};
      STEP_W'(9):          w = '{OP_MEAN,      BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(10):         w = '{OP_MUL_LO,    BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(11):         w = '{OP_MUL_HI,    BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(12):         w = '{OP_STEP_SUM,  BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(13):         w = '{OP_APPLY,     BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(14):         w = '{OP_DIV_GRAD,  BR_NEXT,     SEL_INTERCEPT, STEP_IDLE};
      STEP_WAIT_DIV_ICPT:  w = '{OP_NOP,       BR_DIV_BUSY, SEL_INTERCEPT, STEP_WAIT_DIV_ICPT};
      STEP_W'(16):         w = '{OP_MEAN,      BR_NEXT,     SEL_INTERCEPT, STEP_IDLE};
      STEP_W'(17):         w = '{OP_MUL_LO,    BR_NEXT,     SEL_INTERCEPT, STEP_IDLE};
      STEP_W'(18):         w = '{OP_MUL_HI,    BR_NEXT,     SEL_INTERCEPT, STEP_IDLE};
      STEP_W'(19):         w = '{OP_STEP_SUM,  BR_NEXT,     SEL_INTERCEPT, STEP_IDLE};
      STEP_W'(20):         w = '{OP_APPLY,     BR_NEXT,     SEL_INTERCEPT, STEP_IDLE};
      STEP_W'(21):         w = '{OP_DIV_LOSS,  BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_WAIT_DIV_LOSS:  w = '{OP_NOP,       BR_DIV_BUSY, SEL_SLOPE,     STEP_WAIT_DIV_LOSS};
      STEP_W'(23):         w = '{OP_MEAN_LOSS, BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_W'(24):         w = '{OP_JUDGE,     BR_NEXT,     SEL_SLOPE,     STEP_IDLE};
      STEP_WAIT_OUT:       w = '{OP_NOP,       BR_OUT_BUSY, SEL_SLOPE,     STEP_WAIT_OUT};
      STEP_W'(26):         w = '{OP_EMIT,      BR_ALWAYS,   SEL_SLOPE,     STEP_IDLE};
      default:             w = '{OP_NOP,       BR_ALWAYS,   SEL_SLOPE,     STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/lrgd_sample_if.sv
// Sample channel: one beat carries an (x, y) training pair.
// Depends on lrgd_pkg for the field widths.
`default_nettype none

interface lrgd_sample_if
  import lrgd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] x_value;
  logic signed [WORD_W-1:0] y_value;

  modport source (output valid, output x_value, output y_value, input ready);
  modport sink (input valid, input x_value, input y_value, output ready);
endinterface

`default_nettype wire

FILE: rtl/lrgd_result_if.sv
// Result channel: one beat carries the parameters and loss after a batch.
// Depends on lrgd_pkg for the field widths.
`default_nettype none

interface lrgd_result_if
  import lrgd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] slope;
  logic signed [WORD_W-1:0] intercept;
  logic [LOSS_W-1:0]        mean_loss;
  logic [EPOCH_W-1:0]       epoch_number;
  logic                     finished;

  modport source (output valid, output slope, output intercept, output mean_loss,
                  output epoch_number, output finished, input ready);
  modport sink (input valid, input slope, input intercept, input mean_loss,
                input epoch_number, input finished, output ready);
endinterface

`default_nettype wire

FILE: rtl/lrgd_divider.sv
// Radix-2 restoring divider: unsigned 64-bit dividend by a batch-size divisor.
// One quotient bit per cycle; depends on lrgd_pkg for widths.
`default_nettype none

module lrgd_divider
  import lrgd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [SUM_W-1:0]   dividend,
  input  wire logic [BATCH_W-1:0] divisor,
  output logic                    busy,
  output logic [SUM_W-1:0]        quotient
);

  localparam int COUNT_W = $clog2(SUM_W + 1);

  logic [COUNT_W-1:0] count;
  logic [SUM_W-1:0]   work;
  logic [BATCH_W-1:0] rem;
  logic [BATCH_W-1:0] den;
  logic [BATCH_W:0]   trial;
  logic [BATCH_W:0]   diff;

  assign trial    = {rem, work[SUM_W-1]};
  assign diff     = trial - {1'b0, den};
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= COUNT_W'(SUM_W);
    end else if (busy) begin
      count <= count - COUNT_W'(1);
      if (count == COUNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      den  <= divisor;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem  <= diff[BATCH_W-1:0];
        work <= {work[SUM_W-2:0], 1'b1};
      end else begin
        rem  <= trial[BATCH_W-1:0];
        work <= {work[SUM_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lrgd_datapath.sv
// Trainer datapath: parameter and accumulator registers, one shared 32x32
// multiplier and the divider, driven by the control word. Depends on lrgd_pkg.
`default_nettype none

module lrgd_datapath
  import lrgd_pkg::*;
#(
  parameter int MAX_BATCH     = DEFAULT_MAX_BATCH,
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire ctrl_word_t               cw,
  input  wire cfg_t                     cfg,
  input  wire logic                     slope_load,
  input  wire logic                     intercept_load,
  input  wire logic signed [WORD_W-1:0] param_value,
  input  wire logic signed [WORD_W-1:0] x_in,
  input  wire logic signed [WORD_W-1:0] y_in,
  output dp_status_t                    status,
  output result_t                       res
);

  localparam int BATCH_CODE_MAX = (1 << BATCH_W) - 1;
  localparam int BATCH_LIMIT = (MAX_BATCH < BATCH_CODE_MAX) ? MAX_BATCH : BATCH_CODE_MAX;
  localparam logic [BATCH_W-1:0] BATCH_CAP = BATCH_W'(BATCH_LIMIT);

  localparam logic signed [SUM_W-1:0] I32_MAX = 64'sh0000_0000_7fff_ffff;
  localparam logic signed [SUM_W-1:0] I32_MIN = 64'shffff_ffff_8000_0000;
  localparam logic signed [SUM_W-1:0] I64_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [SUM_W-1:0] I64_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [SUM_W-1:0] MEAN_LIM  = SUM_W'((64'd1 << (MEAN_W - 1)) - 64'd1);
  localparam logic [SUM_W-1:0] LOSS_MASK = SUM_W'((64'd1 << LOSS_W) - 64'd1);

  function automatic logic signed [SUM_W-1:0] sext(input logic signed [WORD_W-1:0] v);
    return $signed({{(SUM_W-WORD_W){v[WORD_W-1]}}, v});
  endfunction

  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [WORD_W-1:0] r;
    if (v > I32_MAX) begin
      r = I32_MAX[WORD_W-1:0];
    end else if (v < I32_MIN) begin
      r = I32_MIN[WORD_W-1:0];
    end else begin
      r = v[WORD_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    logic signed [SUM_W-1:0] r;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      r = s[SUM_W] ? I64_MIN : I64_MAX;
    end else begin
      r = $signed(s[SUM_W-1:0]);
    end
    return r;
  endfunction

  logic signed [WORD_W-1:0] x_reg;
  logic signed [WORD_W-1:0] y_reg;
  logic signed [WORD_W-1:0] err_reg;
  logic signed [SUM_W-1:0]  acc;
  logic signed [SUM_W-1:0]  pacc;
  logic signed [SUM_W-1:0]  prod;
  logic [LOSS_W-1:0]        mean_loss;
  logic                     div_neg;

  logic signed [WORD_W-1:0] slope_reg;
  logic signed [WORD_W-1:0] intercept_reg;
  logic signed [SUM_W-1:0]  slope_gradient_sum;
  logic signed [SUM_W-1:0]  intercept_gradient_sum;
  logic [SUM_W-1:0]         loss_sum;
  logic [BATCH_W-1:0]       sample_counter;
  logic [EPOCH_W-1:0]       epoch_counter;
  logic                     done_flag;

  logic signed [WORD_W-1:0] mul_a;
  logic signed [WORD_W-1:0] mul_b;
  logic signed [SUM_W-1:0]  mul_out;
  logic                     mul_en;
  logic [BATCH_W-1:0]       batch_eff;
  logic [BATCH_W-1:0]       batch_n;
  logic [EPOCH_W-1:0]       epoch_limit;
  logic signed [SUM_W-1:0]  err_diff;
  logic signed [SUM_W-1:0]  neg_prod;
  logic signed [SUM_W-1:0]  slope_term;
  logic signed [SUM_W-1:0]  intercept_term;
  logic [SUM_W-1:0]         sq_term;
  logic [SUM_W:0]           loss_add;
  logic signed [SUM_W-1:0]  grad_src;
  logic                     div_start;
  logic [SUM_W-1:0]         div_dividend;
  logic                     div_busy;
  logic [SUM_W-1:0]         div_q;
  logic [SUM_W-1:0]         mean_mag;
  logic signed [WORD_W-1:0] apply_src;
  logic signed [SUM_W-1:0]  apply_diff;

  assign batch_eff   = (cfg.batch_count == '0) ? BATCH_W'(1) : cfg.batch_count;
  assign batch_n     = (batch_eff > BATCH_CAP) ? BATCH_CAP : batch_eff;
  assign epoch_limit = (cfg.max_epochs == '0) ? EPOCH_W'(1) : cfg.max_epochs;

  always_comb begin
    mul_en = 1'b1;
    case (cw.op)
      OP_MUL_XS: begin
        mul_a = x_reg;
        mul_b = slope_reg;
      end
      OP_MUL_XE: begin
        mul_a = x_reg;
        mul_b = err_reg;
      end
      OP_GRAD: begin
        mul_a = err_reg;
        mul_b = err_reg;
      end
      OP_MUL_LO: begin
        mul_a = $signed({{(WORD_W-MEAN_SPLIT){1'b0}}, acc[MEAN_SPLIT-1:0]});
        mul_b = $signed({{(WORD_W-LR_W){1'b0}}, cfg.learning_rate});
      end
      OP_MUL_HI: begin
        mul_a = $signed({{(WORD_W-(MEAN_W-MEAN_SPLIT)){acc[MEAN_W-1]}},
                         acc[MEAN_W-1:MEAN_SPLIT]});
        mul_b = $signed({{(WORD_W-LR_W){1'b0}}, cfg.learning_rate});
      end
      default: begin
        mul_en = 1'b0;
        mul_a  = x_reg;
        mul_b  = slope_reg;
      end
    endcase
  end

  assign mul_out = mul_a * mul_b;

  assign err_diff       = sext(y_reg) - acc;
  assign neg_prod       = -prod;
  assign slope_term     = neg_prod >>> (FRACTION_BITS - 1);
  assign intercept_term = -(sext(err_reg) <<< 1);
  assign sq_term        = $unsigned(prod) >> FRACTION_BITS;
  assign loss_add       = {1'b0, loss_sum} + {1'b0, sq_term};

  assign grad_src     = (cw.sel == SEL_INTERCEPT) ? intercept_gradient_sum : slope_gradient_sum;
  assign div_start    = (cw.op == OP_DIV_GRAD) || (cw.op == OP_DIV_LOSS);
  assign div_dividend = (cw.op == OP_DIV_LOSS) ? loss_sum :
                        (grad_src[SUM_W-1] ? $unsigned(-grad_src) : $unsigned(grad_src));
  assign mean_mag     = (div_q > MEAN_LIM) ? MEAN_LIM : div_q;

  assign apply_src  = (cw.sel == SEL_INTERCEPT) ? intercept_reg : slope_reg;
  assign apply_diff = sext(apply_src) - (pacc >>> FRACTION_BITS);

  lrgd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (batch_n),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (cw.op == OP_WAIT_IN) begin
      x_reg <= x_in;
      y_reg <= y_in;
    end
    if (mul_en) begin
      prod <= mul_out;
    end
    case (cw.op)
      OP_PRED:     acc <= (prod >>> FRACTION_BITS) + sext(intercept_reg);
      OP_ERR:      err_reg <= sat32(err_diff);
      OP_DIV_GRAD: div_neg <= grad_src[SUM_W-1];
      OP_MEAN:     acc <= div_neg ? -$signed(mean_mag) : $signed(mean_mag);
      OP_MUL_HI:   pacc <= prod;
      OP_STEP_SUM: pacc <= pacc + (prod <<< MEAN_SPLIT);
      OP_MEAN_LOSS: begin
        mean_loss <= (div_q > LOSS_MASK) ? LOSS_MASK[LOSS_W-1:0] : div_q[LOSS_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slope_reg              <= '0;
      intercept_reg          <= '0;
      slope_gradient_sum     <= '0;
      intercept_gradient_sum <= '0;
      loss_sum               <= '0;
      sample_counter         <= '0;
      epoch_counter          <= '0;
      done_flag              <= 1'b0;
    end else begin
      if (slope_load) begin
        slope_reg <= param_value;
      end
      if (intercept_load) begin
        intercept_reg <= param_value;
      end
      case (cw.op)
        OP_ERR: sample_counter <= sample_counter + BATCH_W'(1);
        OP_GRAD: begin
          slope_gradient_sum     <= sat_add(slope_gradient_sum, slope_term);
          intercept_gradient_sum <= sat_add(intercept_gradient_sum, intercept_term);
        end
        OP_LOSS: loss_sum <= loss_add[SUM_W] ? '1 : loss_add[SUM_W-1:0];
        OP_APPLY: begin
          if (cw.sel == SEL_INTERCEPT) begin
            intercept_reg <= sat32(apply_diff);
          end else begin
            slope_reg <= sat32(apply_diff);
          end
        end
        OP_MEAN_LOSS: begin
          if (epoch_counter != '1) begin
            epoch_counter <= epoch_counter + EPOCH_W'(1);
          end
        end
        OP_JUDGE: begin
          done_flag <= (mean_loss <= cfg.loss_threshold) || (epoch_counter >= epoch_limit);
          slope_gradient_sum     <= '0;
          intercept_gradient_sum <= '0;
          loss_sum               <= '0;
          sample_counter         <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  assign status.done     = done_flag;
  assign status.full     = (sample_counter >= batch_n);
  assign status.div_busy = div_busy;

  assign res.slope        = slope_reg;
  assign res.intercept    = intercept_reg;
  assign res.mean_loss    = mean_loss;
  assign res.epoch_number = epoch_counter;
  assign res.finished     = done_flag;

endmodule

`default_nettype wire

FILE: rtl/lrgd_sequencer.sv
// Microcode sequencer: step counter, control program lookup and branch logic.
// Depends on lrgd_pkg for the program and the control word.
`default_nettype none

module lrgd_sequencer
  import lrgd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire seq_flags_t flags,
  output ctrl_word_t      cw
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              taken;

  assign cw = lrgd_rom(step);

  always_comb begin
    case (cw.br)
      BR_NEXT:     taken = 1'b0;
      BR_ALWAYS:   taken = 1'b1;
      BR_NO_GO:    taken = !flags.go;
      BR_NOT_FULL: taken = !flags.full;
      BR_DIV_BUSY: taken = flags.div_busy;
      BR_OUT_BUSY: taken = flags.out_busy;
      default:     taken = 1'b1;
    endcase
    step_next = taken ? cw.target : step + STEP_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/linear_regression_gd_trainer.sv
// Top level of the gradient descent trainer: configuration registers, channel
// handshakes and the result register. Depends on lrgd_pkg, both channel
// interfaces, lrgd_sequencer and lrgd_datapath.
//
//   channel   direction  beat contents
//   sample    in         x_value, y_value
//   result    out        slope, intercept, mean_loss, epoch_number, finished
//   cfg       in         cfg_index, cfg_data on cfg_wr_en
//
// Between one sample beat and the next the sequencer runs steps 1 to 6; the three
// products take turns on the one multiplier, and the last two both use the error
// that the first one yields. The beat that closes a batch adds steps 7 to 26, with
// three divider runs and a wait while the result register still holds a beat.
// Reset is synchronous; there is no clearing pass.
// A result waits in its register while the next batch of samples is taken.
// After finishing, samples are taken and dropped until reset.
`default_nettype none

module linear_regression_gd_trainer
  import lrgd_pkg::*;
#(
  parameter int MAX_BATCH     = DEFAULT_MAX_BATCH,
  parameter int FRACTION_BITS = DEFAULT_FRACTION_BITS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  lrgd_sample_if.sink                sample,
  lrgd_result_if.source              result,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  ctrl_word_t cw;
  seq_flags_t flags;
  dp_status_t status;
  result_t    dp_res;
  result_t    res_reg;
  logic       out_valid;
  logic       slope_load;
  logic       intercept_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.learning_rate  <= LR_RESET;
      cfg.batch_count    <= BATCH_RESET;
      cfg.max_epochs     <= MAX_EPOCHS_RESET;
      cfg.loss_threshold <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_LEARNING_RATE:  cfg.learning_rate  <= cfg_data[LR_W-1:0];
        CFG_BATCH_COUNT:    cfg.batch_count    <= cfg_data[BATCH_W-1:0];
        CFG_MAX_EPOCHS:     cfg.max_epochs     <= cfg_data[EPOCH_W-1:0];
        CFG_LOSS_THRESHOLD: cfg.loss_threshold <= cfg_data[LOSS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign slope_load     = cfg_wr_en && (cfg_index == CFG_INITIAL_SLOPE);
  assign intercept_load = cfg_wr_en && (cfg_index == CFG_INITIAL_INTERCEPT);

  assign sample.ready   = (cw.op == OP_WAIT_IN);
  assign flags.go       = sample.valid && sample.ready && !status.done;
  assign flags.full     = status.full;
  assign flags.div_busy = status.div_busy;
  assign flags.out_busy = out_valid;

  lrgd_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  lrgd_datapath #(
    .MAX_BATCH     (MAX_BATCH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cw             (cw),
    .cfg            (cfg),
    .slope_load     (slope_load),
    .intercept_load (intercept_load),
    .param_value    ($signed(cfg_data[WORD_W-1:0])),
    .x_in           (sample.x_value),
    .y_in           (sample.y_value),
    .status         (status),
    .res            (dp_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.op == OP_EMIT) begin
      res_reg <= dp_res;
    end
  end

  assign result.valid        = out_valid;
  assign result.slope        = res_reg.slope;
  assign result.intercept    = res_reg.intercept;
  assign result.mean_loss    = res_reg.mean_loss;
  assign result.epoch_number = res_reg.epoch_number;
  assign result.finished     = res_reg.finished;

  a_emit_into_empty: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EMIT) |-> !out_valid)
    else $error("result register overwritten while still holding a beat");

  a_stay_idle_when_done: assert property (@(posedge clk) disable iff (rst)
    (status.done && cw.op == OP_WAIT_IN) |=> (cw.op == OP_WAIT_IN))
    else $error("sequencer left idle after training finished");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_DIV_GRAD || cw.op == OP_DIV_LOSS) |-> !status.div_busy)
    else $error("divider restarted while busy");

  a_epoch_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res_reg.epoch_number != '0))
    else $error("result beat with zero epoch number");

endmodule

`default_nettype wire
